// ===== sv/rsbm_pkg.sv =====
// shared types and constants for the range scan background mask
// no dependencies; used by rsbm_outq, the top module and the bench by scoped names
`default_nettype none

package rsbm_pkg;

    // field widths fixed by the sample format
    localparam int RANGE_W = 16;
    localparam int BEAM_W  = 10;

    // default number of mask entries
    localparam int BEAM_COUNT_DEF = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MIN      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_MAX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_THRESHOLD = 2'd2;

    localparam logic [RANGE_W-1:0] RANGE_MIN_RST      = 16'h0000;
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST      = 16'hFFFF;
    localparam logic [RANGE_W-1:0] MASK_THRESHOLD_RST = 16'h0000;

    // command codes
    localparam logic CMD_LEARN  = 1'b0;
    localparam logic CMD_FILTER = 1'b1;

    // result queue sizing
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    typedef struct packed {
        logic               command;
        logic [BEAM_W-1:0]  beam_index;
        logic [RANGE_W-1:0] range_mm;
    } t_in_item;

    typedef struct packed {
        logic sample_valid;
        logic foreground;
    } t_out_item;

    // one mask word: presence flag plus nearest range
    typedef struct packed {
        logic               present;
        logic [RANGE_W-1:0] range_mm;
    } t_mask_entry;

    localparam int MASK_W = $bits(t_mask_entry);

    // result queue status seen by the pipeline
    typedef struct packed {
        logic [OUTQ_CNT_W-1:0] count;
    } t_outq_stat;

endpackage

`default_nettype wire

// ===== sv/rsbm_ram.sv =====
// generic single-port-write, single-port-read synchronous ram
// registered read, read during write at the same address returns old data
`default_nettype none

module rsbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/rsbm_outq.sv =====
// small result queue that decouples the mask pipeline from the output stall
// depends on rsbm_pkg for the result type and queue sizing
`default_nettype none

module rsbm_outq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire rsbm_pkg::t_out_item i_push_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output rsbm_pkg::t_out_item     o_data,
    output rsbm_pkg::t_outq_stat    o_stat
);

    rsbm_pkg::t_out_item r_buf [rsbm_pkg::OUTQ_DEPTH];

    logic [rsbm_pkg::OUTQ_PTR_W-1:0] r_wptr;
    logic [rsbm_pkg::OUTQ_PTR_W-1:0] r_rptr;
    logic [rsbm_pkg::OUTQ_CNT_W-1:0] r_count;
    logic                            pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_data  = r_buf[r_rptr];

    assign o_stat.count = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/range_scan_background_mask.sv =====
// range scan background mask: learn nearest range per beam, flag foreground
// flow: the accept edge issues the mask read, then stage 1 compares, updates and queues
// throughput: one per cycle unless stalled, set by the single mask ram read-modify-write
// reset: synchronous; afterwards the mask ram is swept, one entry a cycle, over all
// BEAM_COUNT entries, during which no input transaction is taken (config writes still are)
// uses rsbm_pkg, rsbm_ram and rsbm_outq
`default_nettype none

module range_scan_background_mask #(
    parameter int BEAM_COUNT = rsbm_pkg::BEAM_COUNT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // configuration writes
    input  wire logic                            i_cfg_we,
    input  wire logic [rsbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [rsbm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // sample transactions in
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire rsbm_pkg::t_in_item              i_in_data,
    // result transactions out
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output rsbm_pkg::t_out_item                  o_out_data
);

    localparam int AW = $clog2(BEAM_COUNT);
    localparam int BW = rsbm_pkg::BEAM_W;
    localparam int RW = rsbm_pkg::RANGE_W;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [RW-1:0] r_range_min;
    logic [RW-1:0] r_range_max;
    logic [RW-1:0] r_mask_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min      <= rsbm_pkg::RANGE_MIN_RST;
            r_range_max      <= rsbm_pkg::RANGE_MAX_RST;
            r_mask_threshold <= rsbm_pkg::MASK_THRESHOLD_RST;
        end else if (i_cfg_we) begin
            // an index past the register list is dropped
            case (i_cfg_idx)
                rsbm_pkg::REG_RANGE_MIN:      r_range_min      <= i_cfg_wdata;
                rsbm_pkg::REG_RANGE_MAX:      r_range_max      <= i_cfg_wdata;
                rsbm_pkg::REG_MASK_THRESHOLD: r_mask_threshold <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // mask clearing sweep after reset
    // presence flags live in the ram word, so every entry is written once
    // ---------------------------------------------------------------
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == AW'(BEAM_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // stage 0: accept and issue the mask read
    // ---------------------------------------------------------------
    rsbm_pkg::t_outq_stat q_stat;
    logic                 in_accept;
    logic                 r_s1_valid;
    logic [rsbm_pkg::OUTQ_CNT_W-1:0] in_flight;

    // results already queued plus the one in the update stage; keeps room
    // so the update stage can always push without waiting
    assign in_flight  = q_stat.count + rsbm_pkg::OUTQ_CNT_W'(r_s1_valid);
    assign o_in_stall = r_clearing
                     || (in_flight >= rsbm_pkg::OUTQ_CNT_W'(rsbm_pkg::OUTQ_DEPTH - 1));
    assign in_accept  = i_in_valid && !o_in_stall;

    rsbm_pkg::t_in_item r_s1_item;
    logic               r_s1_inb;
    logic [AW-1:0]      r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item <= i_in_data;
            r_s1_addr <= AW'(i_in_data.beam_index);
            // beams past the mask size have no entry
            r_s1_inb  <= ({{(17 - BW){1'b0}}, i_in_data.beam_index} < 17'(BEAM_COUNT));
        end
    end

    // ---------------------------------------------------------------
    // mask ram
    // ---------------------------------------------------------------
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    rsbm_pkg::t_mask_entry  ram_wdata;
    rsbm_pkg::t_mask_entry  ram_rdata;
    logic                   upd_we;
    rsbm_pkg::t_mask_entry  upd_entry;

    assign ram_we    = r_clearing || upd_we;
    assign ram_waddr = r_clearing ? r_clr_addr : r_s1_addr;
    assign ram_wdata = r_clearing ? rsbm_pkg::t_mask_entry'('0) : upd_entry;

    rsbm_ram #(
        .WIDTH (rsbm_pkg::MASK_W),
        .DEPTH (BEAM_COUNT)
    ) u_mask_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (in_accept),
        .i_raddr (AW'(i_in_data.beam_index)),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // stage 1: compare and update
    // the ram returns old data when the previous transaction wrote the same
    // entry on the edge of this read, so that write is forwarded
    // ---------------------------------------------------------------
    logic                  r_fwd_valid;
    logic [AW-1:0]         r_fwd_addr;
    rsbm_pkg::t_mask_entry r_fwd_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_valid <= 1'b0;
        end else begin
            r_fwd_valid <= upd_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (upd_we) begin
            r_fwd_addr  <= r_s1_addr;
            r_fwd_entry <= upd_entry;
        end
    end

    rsbm_pkg::t_mask_entry cur_entry;
    logic                  s1_sample_ok;
    logic                  s1_background;
    logic [RW:0]           s1_limit;
    rsbm_pkg::t_out_item   s1_result;

    assign cur_entry = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_entry : ram_rdata;

    // strictly inside the range window
    assign s1_sample_ok = (r_s1_item.range_mm > r_range_min)
                       && (r_s1_item.range_mm < r_range_max);

    // mask - threshold < range, rearranged to avoid wrap
    assign s1_limit      = {1'b0, r_s1_item.range_mm} + {1'b0, r_mask_threshold};
    assign s1_background = r_s1_inb && cur_entry.present
                        && ({1'b0, cur_entry.range_mm} < s1_limit);

    // learn keeps the nearest range seen
    assign upd_we = r_s1_valid && (r_s1_item.command == rsbm_pkg::CMD_LEARN)
                 && s1_sample_ok && r_s1_inb
                 && (!cur_entry.present || (cur_entry.range_mm > r_s1_item.range_mm));

    assign upd_entry.present  = 1'b1;
    assign upd_entry.range_mm = r_s1_item.range_mm;

    assign s1_result.sample_valid = s1_sample_ok;
    assign s1_result.foreground   = (r_s1_item.command == rsbm_pkg::CMD_FILTER)
                                 && s1_sample_ok && !s1_background;

    // ---------------------------------------------------------------
    // result queue
    // ---------------------------------------------------------------
    rsbm_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (r_s1_valid),
        .i_push_data (s1_result),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_data      (o_out_data),
        .o_stat      (q_stat)
    );

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_accept)
        else $error("transaction accepted during mask sweep");

    a_no_update_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !r_s1_valid)
        else $error("mask update overlaps the sweep");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (q_stat.count < rsbm_pkg::OUTQ_CNT_W'(rsbm_pkg::OUTQ_DEPTH)))
        else $error("result queue full while a result is pushed");

    a_sweep_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |=> !r_clearing)
        else $error("mask sweep restarted without reset");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// testbench for range_scan_background_mask: directed and random sample streams
// checked against an in-bench mask predictor; depends on rsbm_pkg and the rtl only
`default_nettype none

module testbench;

    localparam int NUM_BEAMS  = 1024;
    localparam int CYCLE_CAP  = 400000;
    localparam int SETTLE_CYC = 4;
    localparam int GAP_MAX    = 18;

    // index with no register behind it, writes there must be ignored
    localparam logic [rsbm_pkg::CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

    // clock, reset and block ports
    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [rsbm_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [rsbm_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_in_valid;
    logic                            o_in_stall;
    rsbm_pkg::t_in_item              i_in_data;
    logic                            o_out_valid;
    logic                            i_out_stall;
    rsbm_pkg::t_out_item             o_out_data;

    // shadow of the configuration registers
    logic [rsbm_pkg::RANGE_W-1:0] lim_lo;
    logic [rsbm_pkg::RANGE_W-1:0] lim_hi;
    logic [rsbm_pkg::RANGE_W-1:0] mask_thr;

    // shadow of the background mask: nearest range and presence per beam
    logic [rsbm_pkg::RANGE_W-1:0] mask_near [NUM_BEAMS];
    bit                           mask_set  [NUM_BEAMS];

    // predicted classifications, oldest first
    rsbm_pkg::t_out_item pending_class[$];

    int fail_count = 0;
    int cycle_count = 0;

    // idling controls for both sides
    int in_gap_max = GAP_MAX;
    int out_gap_max = GAP_MAX;
    int hold_req = 0;
    int hold_left = 0;
    int stall_left = 0;
    bit result_taken = 1'b0;

    range_scan_background_mask uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // run limit, well above the slowest legal run including the reset sweep
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_CAP) begin
            $error("timeout after %0d cycles, %0d results outstanding", cycle_count,
                   pending_class.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    // classify one sample and fold it into the mask shadow
    function automatic rsbm_pkg::t_out_item classify_sample(rsbm_pkg::t_in_item s);
        rsbm_pkg::t_out_item          res;
        logic                         in_window;
        logic                         explained;
        logic [rsbm_pkg::RANGE_W:0]   reach;
        in_window = (s.range_mm > lim_lo) && (s.range_mm < lim_hi);
        res.sample_valid = in_window;
        res.foreground = 1'b0;
        if (s.command == rsbm_pkg::CMD_LEARN) begin
            // keep the nearest range seen for the beam
            if (in_window && (!mask_set[s.beam_index] || mask_near[s.beam_index] > s.range_mm))
            begin
                mask_near[s.beam_index] = s.range_mm;
                mask_set[s.beam_index] = 1'b1;
            end
        end else if (in_window) begin
            // compare at 17 bits so a large margin never wraps
            reach = {1'b0, s.range_mm} + {1'b0, mask_thr};
            explained = mask_set[s.beam_index] && ({1'b0, mask_near[s.beam_index]} < reach);
            res.foreground = !explained;
        end
        return res;
    endfunction

    // scoreboard: check the result side first, then record the new sample
    always @(posedge i_clk) begin
        rsbm_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_taken = 1'b1;
                if (pending_class.size() == 0) begin
                    $error("result transaction with no sample outstanding");
                    fail_count++;
                end else begin
                    want = pending_class.pop_front();
                    if (o_out_data.sample_valid !== want.sample_valid) begin
                        $error("sample_valid mismatch: expected %0d, got %0d",
                               want.sample_valid, o_out_data.sample_valid);
                        fail_count++;
                    end
                    if (o_out_data.foreground !== want.foreground) begin
                        $error("foreground mismatch: expected %0d, got %0d",
                               want.foreground, o_out_data.foreground);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                pending_class = {pending_class, classify_sample(i_in_data)};
            end
        end
    end

    // result side: per-transaction random stall, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (result_taken) begin
            result_taken = 1'b0;
            stall_left = $urandom_range(0, out_gap_max);
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // offer one sample transaction; entered and left at a falling edge
    task automatic send_sample(input logic cmd, input int beam, input int rng);
        int gap;
        rsbm_pkg::t_in_item s;
        gap = $urandom_range(0, in_gap_max);
        s.command = cmd;
        s.beam_index = beam[rsbm_pkg::BEAM_W-1:0];
        s.range_mm = rng[rsbm_pkg::RANGE_W-1:0];
        // valid stays high across back-to-back transactions
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= s;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // stop offering, wait for every outstanding result, then let the pipe empty
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        while (pending_class.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYC) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [rsbm_pkg::CFG_IDX_W-1:0] idx, input int value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= value[rsbm_pkg::CFG_DATA_W-1:0];
        case (idx)
            rsbm_pkg::REG_RANGE_MIN:      lim_lo = value[rsbm_pkg::RANGE_W-1:0];
            rsbm_pkg::REG_RANGE_MAX:      lim_hi = value[rsbm_pkg::RANGE_W-1:0];
            rsbm_pkg::REG_MASK_THRESHOLD: mask_thr = value[rsbm_pkg::RANGE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // mostly a range inside the window, sometimes anything at all
    function automatic int window_range();
        if ($urandom_range(0, 9) == 0 || int'(lim_hi) - int'(lim_lo) < 2) begin
            return $urandom_range(0, 65535);
        end
        return $urandom_range(int'(lim_lo) + 1, int'(lim_hi) - 1);
    endfunction

    // filter ranges cluster around the background edge of a learned beam
    function automatic int filter_range(int beam);
        int r;
        int jitter;
        if (mask_set[beam] && $urandom_range(0, 3) != 0) begin
            jitter = $urandom_range(0, 4);
            r = int'(mask_near[beam]) - int'(mask_thr) + jitter - 2;
            if (r < 0) r = 0;
            if (r > 65535) r = 65535;
        end else begin
            r = window_range();
        end
        return r;
    endfunction

    // reset window: limits exclusive at both ends, mask keeps the nearest range
    task automatic test_default_window();
        send_sample(rsbm_pkg::CMD_LEARN, 0, 0);
        send_sample(rsbm_pkg::CMD_FILTER, 0, 0);
        send_sample(rsbm_pkg::CMD_FILTER, 0, 100);        // no entry, so foreground
        send_sample(rsbm_pkg::CMD_LEARN, 0, 65535);
        send_sample(rsbm_pkg::CMD_LEARN, 1023, 65534);
        send_sample(rsbm_pkg::CMD_LEARN, 1023, 65534);    // equal range leaves entry alone
        send_sample(rsbm_pkg::CMD_LEARN, 1023, 1);        // nearer range replaces it
        send_sample(rsbm_pkg::CMD_LEARN, 1023, 300);      // farther range ignored
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 1);       // equal to mask, not behind it
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 2);
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 65534);
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 65535);
        settle_idle();
    endtask

    // margin at its extremes and at the exact comparison boundary
    task automatic test_threshold_margin();
        cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, 65535);
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 1);       // sum exceeds 16 bits, still background
        send_sample(rsbm_pkg::CMD_FILTER, 1023, 65534);
        settle_idle();
        cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, 100);
        send_sample(rsbm_pkg::CMD_LEARN, 512, 1000);
        send_sample(rsbm_pkg::CMD_FILTER, 512, 900);
        send_sample(rsbm_pkg::CMD_FILTER, 512, 901);
        send_sample(rsbm_pkg::CMD_FILTER, 511, 900);
        settle_idle();
    endtask

    // windows with no valid range, ignored register index, narrow window edges
    task automatic test_empty_window();
        cfg_write(rsbm_pkg::REG_RANGE_MIN, 5);
        cfg_write(rsbm_pkg::REG_RANGE_MAX, 6);
        send_sample(rsbm_pkg::CMD_LEARN, 7, 5);
        send_sample(rsbm_pkg::CMD_FILTER, 7, 6);
        settle_idle();
        cfg_write(rsbm_pkg::REG_RANGE_MIN, 65535);
        cfg_write(rsbm_pkg::REG_RANGE_MAX, 0);
        send_sample(rsbm_pkg::CMD_FILTER, 7, 100);
        settle_idle();
        cfg_write(REG_UNUSED_IDX, 65535);
        cfg_write(rsbm_pkg::REG_RANGE_MIN, 100);
        cfg_write(rsbm_pkg::REG_RANGE_MAX, 200);
        cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, 0);
        send_sample(rsbm_pkg::CMD_LEARN, 8, 100);
        send_sample(rsbm_pkg::CMD_LEARN, 8, 101);
        send_sample(rsbm_pkg::CMD_FILTER, 8, 199);
        send_sample(rsbm_pkg::CMD_FILTER, 8, 200);
        settle_idle();
    endtask

    // receiver holds off while the sender keeps offering, so input stall must rise
    task automatic test_backpressure();
        int k;
        in_gap_max = 0;
        hold_req = 300;
        for (k = 0; k < 40; k++) begin
            send_sample(1'($urandom_range(0, 1)), $urandom_range(100, 115), window_range());
        end
        settle_idle();
        in_gap_max = GAP_MAX;
    endtask

    // random phases: fresh limits, then learn and filter sweeps over a beam span
    task automatic test_random_scans();
        int phase;
        int sent;
        int lo;
        int hi;
        int base;
        int span;
        int k;
        int beam;
        for (phase = 0; phase < 6; phase++) begin
            case ($urandom_range(0, 5))
                0: begin
                    lo = 0;
                    hi = 65535;
                end
                1: begin
                    lo = $urandom_range(0, 65535);
                    hi = $urandom_range(0, 65535);
                end
                default: begin
                    lo = $urandom_range(0, 3000);
                    hi = lo + $urandom_range(2, 62000);
                end
            endcase
            cfg_write(rsbm_pkg::REG_RANGE_MIN, lo);
            cfg_write(rsbm_pkg::REG_RANGE_MAX, hi);
            case ($urandom_range(0, 4))
                0: cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, 0);
                1: cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, 65535);
                2: cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, $urandom_range(0, 65535));
                default: cfg_write(rsbm_pkg::REG_MASK_THRESHOLD, $urandom_range(0, 2000));
            endcase
            // some phases run with no idling on one side or both
            in_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            out_gap_max = ($urandom_range(0, 2) == 0) ? 0 : GAP_MAX;
            base = $urandom_range(0, NUM_BEAMS - 1);
            span = $urandom_range(4, 24);
            sent = 0;
            while (sent < 100) begin
                for (k = 0; k < span; k++) begin
                    beam = (base + k) % NUM_BEAMS;
                    send_sample(rsbm_pkg::CMD_LEARN, beam, window_range());
                end
                for (k = 0; k < span; k++) begin
                    beam = (base + k) % NUM_BEAMS;
                    send_sample(rsbm_pkg::CMD_FILTER, beam, filter_range(beam));
                end
                sent += 2 * span;
                // stray samples anywhere in the scan
                repeat ($urandom_range(0, 6)) begin
                    send_sample(1'($urandom_range(0, 1)), $urandom_range(0, NUM_BEAMS - 1),
                                $urandom_range(0, 65535));
                    sent++;
                end
            end
            settle_idle();
        end
        in_gap_max = GAP_MAX;
        out_gap_max = GAP_MAX;
    endtask

    initial begin
        int b;
        // every input known from time zero
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = rsbm_pkg::REG_RANGE_MIN;
        i_cfg_wdata = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_stall = 1'b0;
        lim_lo = rsbm_pkg::RANGE_MIN_RST;
        lim_hi = rsbm_pkg::RANGE_MAX_RST;
        mask_thr = rsbm_pkg::MASK_THRESHOLD_RST;
        for (b = 0; b < NUM_BEAMS; b++) begin
            mask_near[b] = '0;
            mask_set[b] = 1'b0;
        end
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // the mask sweep after reset holds off the first transaction by itself
        test_default_window();
        test_threshold_margin();
        test_empty_window();
        test_backpressure();
        test_random_scans();
        settle_idle();

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
sv/rsbm_pkg.sv
sv/rsbm_ram.sv
sv/rsbm_outq.sv
sv/range_scan_background_mask.sv
bench/testbench.sv
